@@ rtl/ipsp_pkg.sv @@
// Package for the IPS patch stream parser: parse phases, result kinds,
// the result beat struct, header magic and size constants.
// No dependencies.
package ipsp_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [24:0] IMAGE_SIZE_RESET = 25'h100_0000;
    localparam logic [23:0] EOF_MARK         = 24'h454F46;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_OFFSET   = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_DATA     = 3'd3,
        PH_RUNCOUNT = 3'd4,
        PH_RUNVALUE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_OK    = 2'd2,
        KIND_FAIL  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] addr;
        logic [15:0] run;
        logic [7:0]  value;
        logic        last;
    } result_t;

    localparam result_t FAIL_RESULT = '{
        kind:  KIND_FAIL,
        addr:  24'd0,
        run:   16'd0,
        value: 8'd0,
        last:  1'b1
    };

    // "PATCH"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                3'd0:    b = 8'h50;
                3'd1:    b = 8'h41;
                3'd2:    b = 8'h54;
                3'd3:    b = 8'h43;
                3'd4:    b = 8'h48;
                default: b = 8'h50;
            endcase
            return b;
        end
    endfunction

endpackage

@@ rtl/ips_patch_stream_parser.sv @@
// IPS patch stream parser top level: byte parser state and result queue.
// Depends on ipsp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one patch file byte per beat
//   with file_end marking the final byte of the file. The file must open
//   with "PATCH", followed by offset/length records and an "EOF" marker.
//   Output channel (out_valid/out_ready) carries one result per beat:
//   byte write, fill run, patch finished ok or patch failed; last_result
//   flags the final result caused by one input byte.
//   image_size is written through cfg_write_en/cfg_write_data; the user must
//   do so only while idle, as the block itself does not enforce it.
//   Throughput: one byte per cycle while in_ready is high. Each byte is
//   parsed in the accept cycle and its zero, one or two results go into
//   a 4-beat result queue; in_ready is high while it has room for two beats.
//   Receiver stall: in_ready drops once three or more beats wait in the
//   queue, which holds up to four; nothing is lost.
//   Reset: parser returns to the header phase, queue empties, image_size
//   returns to 2^24. After a finish or failure, bytes are dropped until the
//   byte marked file_end re-arms the parser.
module ips_patch_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [24:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  patch_byte,
    input  logic        file_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [23:0] target_address,
    output logic [15:0] run_length,
    output logic [7:0]  byte_value,
    output logic        last_result
);
    import ipsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [23:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] remain_reg, remain_next;
    logic        stopped_reg, stopped_next;
    logic [24:0] image_size_reg;

    result_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    logic        in_acc, out_acc;
    logic [23:0] offset_shift;
    logic [15:0] length_shift;
    logic [24:0] span;
    logic        over;
    logic        header_ok;

    result_t     prim;
    logic        prim_valid;
    logic        prim_done;
    logic        tail_fail;
    logic        done_any;
    logic [1:0]  push_cnt;
    result_t     entry0;
    result_t     entry1;
    result_t     head;

    assign in_ready  = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_acc   = out_valid && out_ready;

    assign offset_shift = {offset_reg[15:0], patch_byte};
    assign length_shift = {length_reg[7:0], patch_byte};
    assign span         = {1'b0, offset_reg} + {9'd0, length_shift};
    assign over         = (span > image_size_reg);
    assign header_ok    = (patch_byte == magic_byte(cnt_reg));

    // results of one byte
    always_comb
    begin
        prim       = FAIL_RESULT;
        prim_valid = 1'b0;
        prim_done  = 1'b0;
        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (!header_ok)
                    begin
                        prim_valid = 1'b1;
                        prim_done  = 1'b1;
                    end
                end
                PH_OFFSET:
                begin
                    if (cnt_reg == 3'd2 && offset_shift == EOF_MARK)
                    begin
                        prim.kind  = KIND_OK;
                        prim_valid = 1'b1;
                        prim_done  = 1'b1;
                    end
                end
                PH_LENGTH:
                begin
                    if (cnt_reg == 3'd1 && length_shift != 16'd0 && over)
                    begin
                        prim_valid = 1'b1;
                        prim_done  = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    prim.kind  = KIND_WRITE;
                    prim.addr  = offset_reg;
                    prim.run   = 16'd1;
                    prim.value = patch_byte;
                    prim_valid = 1'b1;
                end
                PH_RUNCOUNT:
                begin
                    if (cnt_reg == 3'd1 && over)
                    begin
                        prim_valid = 1'b1;
                        prim_done  = 1'b1;
                    end
                end
                PH_RUNVALUE:
                begin
                    if (length_reg != 16'd0)
                    begin
                        prim.kind  = KIND_FILL;
                        prim.addr  = offset_reg;
                        prim.run   = length_reg;
                        prim.value = patch_byte;
                        prim_valid = 1'b1;
                    end
                end
                default:
                begin
                    prim_valid = 1'b1;
                    prim_done  = 1'b1;
                end
            endcase
        end
        tail_fail   = !stopped_reg && !prim_done && file_end;
        done_any    = prim_done || tail_fail;
        push_cnt    = {1'b0, prim_valid} + {1'b0, tail_fail};
        entry0      = prim_valid ? prim : FAIL_RESULT;
        entry0.last = prim_valid ? !tail_fail : 1'b1;
        entry1      = FAIL_RESULT;
    end

    // parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        stopped_next = stopped_reg;
        if (in_acc && !stopped_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (header_ok)
                    begin
                        if (cnt_reg == 3'd4)
                        begin
                            phase_next = PH_OFFSET;
                            cnt_next   = 3'd0;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                end
                PH_OFFSET:
                begin
                    offset_next = offset_shift;
                    if (cnt_reg == 3'd2)
                    begin
                        cnt_next = 3'd0;
                        if (offset_shift != EOF_MARK)
                            phase_next = PH_LENGTH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_LENGTH:
                begin
                    length_next = length_shift;
                    if (cnt_reg == 3'd1)
                    begin
                        cnt_next = 3'd0;
                        if (length_shift == 16'd0)
                        begin
                            phase_next = PH_RUNCOUNT;
                        end
                        else if (!over)
                        begin
                            remain_next = length_shift;
                            phase_next  = PH_DATA;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_DATA:
                begin
                    offset_next = offset_reg + 24'd1;
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1)
                        phase_next = PH_OFFSET;
                end
                PH_RUNCOUNT:
                begin
                    length_next = length_shift;
                    if (cnt_reg == 3'd1)
                    begin
                        cnt_next = 3'd0;
                        if (!over)
                            phase_next = PH_RUNVALUE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_RUNVALUE:
                begin
                    phase_next = PH_OFFSET;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
            if (done_any && !file_end)
                stopped_next = 1'b1;
        end
        // re-arm on the marked last byte
        if (in_acc && file_end && (stopped_reg || done_any))
        begin
            phase_next   = PH_HEADER;
            cnt_next     = 3'd0;
            offset_next  = 24'd0;
            length_next  = 16'd0;
            remain_next  = 16'd0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            cnt_reg        <= 3'd0;
            offset_reg     <= 24'd0;
            length_reg     <= 16'd0;
            remain_reg     <= 16'd0;
            stopped_reg    <= 1'b0;
            image_size_reg <= IMAGE_SIZE_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            remain_reg  <= remain_next;
            stopped_reg <= stopped_next;
            if (cfg_write_en)
                image_size_reg <= cfg_write_data;
        end
    end

    // result queue
    always_comb
    begin
        count_next = count_reg + (in_acc ? FIFO_CW'(push_cnt) : '0)
                   - FIFO_CW'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_acc)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_cnt);
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && push_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= entry0;
        if (in_acc && push_cnt == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= entry1;
    end

    assign head           = fifo_reg[rd_ptr_reg];
    assign result_kind    = head.kind;
    assign target_address = head.addr;
    assign run_length     = head.run;
    assign byte_value     = head.value;
    assign last_result    = head.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && stopped_reg) |-> (push_cnt == 2'd0))
        else $error("result pushed while stopped");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && file_end) |=> (phase_reg == PH_HEADER && !stopped_reg
                                  && cnt_reg == 3'd0))
        else $error("parser not re-armed after last byte");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_OK || result_kind == KIND_FAIL))
        |-> (target_address == 24'd0 && run_length == 16'd0 && last_result))
        else $error("status result carries payload");

endmodule

@@ tb/tb_top.sv @@
// Testbench for ips_patch_stream_parser: builds IPS patch files, streams them
// byte by byte and checks every result beat against a local parser model.
// Depends on ipsp_pkg and the ips_patch_stream_parser RTL.
`timescale 1ns / 1ps

module tb_top;

    import ipsp_pkg::*;

    localparam logic [39:0] HEADER_TEXT = "PATCH";
    localparam logic [24:0] IMAGE_SIZE_MAX = 25'h100FFFE;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [24:0] cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  patch_byte;
    logic        file_end;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [23:0] target_address;
    logic [15:0] run_length;
    logic [7:0]  byte_value;
    logic        last_result;

    // parser model state
    phase_t      prs_phase;
    logic [2:0]  prs_count;
    logic [23:0] prs_offset;
    logic [15:0] prs_length;
    logic [15:0] prs_left;
    logic        prs_halted;
    logic [24:0] img_size;

    result_t     expected_q [$];
    result_t     got;
    result_t     want;
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          tx_burst = 0;

    logic [7:0]  file_q [$];

    bit          hold_req = 1'b0;
    int          hold_len = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [7:0]  rx_tick = 8'd0;

    ips_patch_stream_parser i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .patch_byte     (patch_byte),
        .file_end       (file_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .target_address (target_address),
        .run_length     (run_length),
        .byte_value     (byte_value),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic result_t make_result(input kind_t k, input logic [23:0] a,
                                            input logic [15:0] rl, input logic [7:0] v);
        result_t r;
        r.kind  = k;
        r.addr  = a;
        r.run   = rl;
        r.value = v;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic void parser_restart();
        prs_phase  = PH_HEADER;
        prs_count  = 3'd0;
        prs_offset = 24'd0;
        prs_length = 16'd0;
        prs_left   = 16'd0;
        prs_halted = 1'b0;
    endfunction

    task automatic parse_beat(input logic [7:0] b, input logic fin);
        result_t r [0:1];
        int      n;
        logic    done;
        n    = 0;
        done = 1'b0;
        if (prs_halted)
        begin
            if (fin)
                parser_restart();
            return;
        end
        case (prs_phase)
            PH_HEADER:
            begin
                if (b != HEADER_TEXT[39 - 8 * prs_count -: 8])
                begin
                    r[n] = make_result(KIND_FAIL, 24'd0, 16'd0, 8'd0);
                    n++;
                    done = 1'b1;
                end
                else if (prs_count >= 3'd4)
                begin
                    prs_phase = PH_OFFSET;
                    prs_count = 3'd0;
                end
                else
                    prs_count++;
            end
            PH_OFFSET:
            begin
                prs_offset = {prs_offset[15:0], b};
                prs_count++;
                if (prs_count == 3'd3)
                begin
                    prs_count = 3'd0;
                    if (prs_offset == EOF_MARK)
                    begin
                        r[n] = make_result(KIND_OK, 24'd0, 16'd0, 8'd0);
                        n++;
                        done = 1'b1;
                    end
                    else
                        prs_phase = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                prs_length = {prs_length[7:0], b};
                prs_count++;
                if (prs_count == 3'd2)
                begin
                    prs_count = 3'd0;
                    if (prs_length == 16'd0)
                        prs_phase = PH_RUNCOUNT;
                    else if (32'(prs_offset) + 32'(prs_length) > 32'(img_size))
                    begin
                        r[n] = make_result(KIND_FAIL, 24'd0, 16'd0, 8'd0);
                        n++;
                        done = 1'b1;
                    end
                    else
                    begin
                        prs_left  = prs_length;
                        prs_phase = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                r[n] = make_result(KIND_WRITE, prs_offset, 16'd1, b);
                n++;
                prs_offset = prs_offset + 24'd1;
                prs_left   = prs_left - 16'd1;
                if (prs_left == 16'd0)
                    prs_phase = PH_OFFSET;
            end
            PH_RUNCOUNT:
            begin
                prs_length = {prs_length[7:0], b};
                prs_count++;
                if (prs_count == 3'd2)
                begin
                    prs_count = 3'd0;
                    if (32'(prs_offset) + 32'(prs_length) > 32'(img_size))
                    begin
                        r[n] = make_result(KIND_FAIL, 24'd0, 16'd0, 8'd0);
                        n++;
                        done = 1'b1;
                    end
                    else
                        prs_phase = PH_RUNVALUE;
                end
            end
            PH_RUNVALUE:
            begin
                if (prs_length != 16'd0)
                begin
                    r[n] = make_result(KIND_FILL, prs_offset, prs_length, b);
                    n++;
                end
                prs_phase = PH_OFFSET;
            end
            default:
            begin
                r[n] = make_result(KIND_FAIL, 24'd0, 16'd0, 8'd0);
                n++;
                done = 1'b1;
            end
        endcase
        if (!done && fin)
        begin
            r[n] = make_result(KIND_FAIL, 24'd0, 16'd0, 8'd0);
            n++;
            done = 1'b1;
        end
        if (done)
        begin
            if (fin)
                parser_restart();
            else
                prs_halted = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                r[i].last = 1'b1;
            expected_q.push_back(r[i]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.kind  = kind_t'(result_kind);
                got.addr  = target_address;
                got.run   = run_length;
                got.value = byte_value;
                got.last  = last_result;
                if (expected_q.size() == 0)
                begin
                    if (mismatch_count < 50)
                        $display("%0t: unexpected result kind=%0d addr=%06h run=%0d value=%02h last=%b",
                                 $time, got.kind, got.addr, got.run, got.value, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < 50)
                            $display({"%0t: mismatch expected kind=%0d addr=%06h run=%0d value=%02h ",
                                      "last=%b, actual kind=%0d addr=%06h run=%0d value=%02h last=%b"},
                                     $time, want.kind, want.addr, want.run, want.value, want.last,
                                     got.kind, got.addr, got.run, got.value, got.last);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                parse_beat(patch_byte, file_end);
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(3, 0));
                    rx_left = $urandom_range(160, 16);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
                    RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
                    default:   out_ready <= rx_tick[2];
                endcase
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic fin);
        int gap;
        if (tx_burst == 0)
        begin
            gap = ($urandom_range(7, 0) == 0) ? $urandom_range(30, 8) : $urandom_range(4, 0);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tx_burst = $urandom_range(48, 1);
        end
        tx_burst--;
        in_valid   <= 1'b1;
        patch_byte <= b;
        file_end   <= fin;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        items_sent++;
    endtask

    // hold the input and wait out every pending result
    task automatic drain();
        in_valid <= 1'b0;
        tx_burst = 0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_image_size(input logic [24:0] v);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        img_size = v;
    endtask

    function automatic void put_header();
        for (int k = 0; k < 5; k++)
            file_q.push_back(HEADER_TEXT[39 - 8 * k -: 8]);
    endfunction

    function automatic void put_field24(input logic [23:0] v);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[7:0]);
    endfunction

    function automatic void put_data_record(input logic [23:0] off, input logic [15:0] len);
        put_field24(off);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[7:0]);
        for (int k = 0; k < int'(len); k++)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_run_record(input logic [23:0] off, input logic [15:0] cnt,
                                           input logic [7:0] v);
        put_field24(off);
        file_q.push_back(8'd0);
        file_q.push_back(8'd0);
        file_q.push_back(cnt[15:8]);
        file_q.push_back(cnt[7:0]);
        file_q.push_back(v);
    endfunction

    function automatic void put_eof();
        put_field24(EOF_MARK);
    endfunction

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_beat(file_q[i], i == file_q.size() - 1);
        file_q.delete();
    endtask

    function automatic logic [23:0] pick_offset(input logic [31:0] span);
        logic [31:0] top;
        if ($urandom_range(99, 0) < 80 && 32'(img_size) >= span)
        begin
            top = 32'(img_size) - span;
            if (top > 32'hFFFFFF)
                top = 32'hFFFFFF;
            case ($urandom_range(2, 0))
                0:       return 24'($urandom_range(top, 0));
                1:       return top[23:0];
                default: return 24'($urandom_range((top < 64) ? top : 64, 0));
            endcase
        end
        return 24'($urandom);
    endfunction

    task automatic gen_random_file();
        int          recs;
        int          pos;
        int          cut;
        logic [15:0] len;
        logic [15:0] cnt;
        put_header();
        if ($urandom_range(99, 0) < 8)
        begin
            pos = $urandom_range(4, 0);
            file_q[pos] = file_q[pos] ^ 8'($urandom_range(255, 1));
        end
        recs = $urandom_range(5, 0);
        repeat (recs)
        begin
            if ($urandom_range(2, 0) == 0)
            begin
                case ($urandom_range(3, 0))
                    0:       cnt = 16'd0;
                    1:       cnt = 16'($urandom_range(16, 1));
                    2:       cnt = 16'($urandom);
                    default: cnt = 16'hFFFF;
                endcase
                put_run_record(pick_offset(32'(cnt)), cnt, 8'($urandom));
            end
            else
            begin
                len = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(40, 7))
                                                  : 16'($urandom_range(6, 1));
                put_data_record(pick_offset(32'(len)), len);
            end
        end
        if ($urandom_range(99, 0) < 85)
        begin
            put_eof();
            repeat ($urandom_range(3, 0))
                file_q.push_back(8'($urandom));
        end
        if ($urandom_range(99, 0) < 12)
        begin
            cut = $urandom_range(file_q.size(), 1);
            while (file_q.size() > cut)
                void'(file_q.pop_back());
        end
        send_file();
    endtask

    task automatic test_directed();
        put_header();
        put_field24(24'h000000);
        file_q.push_back(8'h00);
        file_q.push_back(8'h01);
        file_q.push_back(8'h00);
        put_field24(24'hFFFFFF);
        file_q.push_back(8'h00);
        file_q.push_back(8'h01);
        file_q.push_back(8'hFF);
        put_run_record(24'h000100, 16'h0000, 8'h55);
        put_eof();
        file_q.push_back(8'hFF);
        send_file();
        file_q.push_back(8'h50);
        file_q.push_back(8'h41);
        file_q.push_back(8'h58);
        file_q.push_back(8'h50);
        send_file();
    endtask

    task automatic test_image_bounds();
        set_image_size(IMAGE_SIZE_MAX);
        put_header();
        put_data_record(24'hFFFFFE, 16'd4);
        put_run_record(24'hFFFF00, 16'hFFFF, 8'hA5);
        put_run_record(24'hFFFFFF, 16'hFFFF, 8'h5A);
        put_eof();
        send_file();
        set_image_size(25'd100);
        put_header();
        put_data_record(24'd99, 16'd1);
        put_data_record(24'd99, 16'd2);
        put_eof();
        send_file();
        set_image_size(25'd0);
        put_header();
        put_run_record(24'd0, 16'd0, 8'h11);
        put_data_record(24'd0, 16'd1);
        put_eof();
        send_file();
        set_image_size(IMAGE_SIZE_RESET);
    endtask

    task automatic test_early_end();
        put_header();
        put_data_record(24'h123456, 16'd3);
        void'(file_q.pop_back());
        send_file();
        file_q.push_back(8'h50);
        file_q.push_back(8'h41);
        file_q.push_back(8'h54);
        send_file();
    endtask

    task automatic test_backpressure();
        drain();
        hold_len = 300;
        hold_req = 1'b1;
        repeat (3)
        begin
            put_header();
            repeat (3) put_data_record(pick_offset(32'd8), 16'd8);
            put_eof();
            send_file();
        end
        drain();
    endtask

    task automatic test_random_files();
        int target;
        target = items_sent;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_image_size(IMAGE_SIZE_MAX);
                1:       set_image_size(25'($urandom_range(4096, 1)));
                2:       set_image_size(IMAGE_SIZE_RESET);
                3:       set_image_size(25'd0);
                4:       set_image_size(25'($urandom_range(IMAGE_SIZE_MAX, 0)));
                default: set_image_size(25'd65536);
            endcase
            target += (phase == 3) ? 120 : 280;
            while (items_sent < target)
                gen_random_file();
        end
    endtask

    task automatic test_noise();
        repeat (150)
            send_beat(8'($urandom), $urandom_range(15, 0) == 0);
        send_beat(8'($urandom), 1'b1);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 25'd0;
        in_valid       = 1'b0;
        patch_byte     = 8'd0;
        file_end       = 1'b0;
        img_size       = IMAGE_SIZE_RESET;
        parser_restart();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_early_end();
        test_image_bounds();
        test_backpressure();
        test_random_files();
        test_noise();
        drain();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ipsp_pkg.sv
rtl/ips_patch_stream_parser.sv
tb/tb_top.sv
